>>> rtl/assert_macros.svh
// assertion macros used by the checker file lfu_pr_checker
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion with explicit clock and active-low reset
`define CHK_ASSERT(name, clk, rstn, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// same on the block clock and reset
`define CHK_ASSERT_ACLK(name, prop, msg) \
    `CHK_ASSERT(name, aclk, aresetn, prop, msg)

`endif

>>> rtl/lfu_pr_pkg.sv
// types and constants for the lfu page replacement block
// no dependencies
package lfu_pr_pkg;

    localparam int WAYS_W      = 5;
    localparam int PAGE_IN_W   = 16;
    localparam int FRAME_OUT_W = 4;
    localparam int COUNT_W     = 16;
    localparam int STAMP_W     = 32;
    localparam int TOTAL_W     = 32;

    localparam int M_TDATA_USED = FRAME_OUT_W + PAGE_IN_W + 2 * TOTAL_W;
    localparam int M_TDATA_W    = ((M_TDATA_USED + 7) / 8) * 8;
    localparam int M_TDATA_PAD  = M_TDATA_W - M_TDATA_USED;
    localparam int M_TUSER_W    = 2;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
    localparam logic [COUNT_W-1:0] COUNT_NEW = COUNT_W'(1);

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_SCAN   = 4'b0010,
        ST_DRAIN  = 4'b0100,
        ST_DECIDE = 4'b1000
    } state_t;

endpackage

>>> rtl/lfu_page_replacement.sv
// lfu page frame table: one frame compared per cycle, one shared compare unit
// path to m_tvalid: scan of the filled frames, drain, decide; only decide when none is filled
// the next input is taken only in idle, after decide; decide waits while a result is stalled
// a waiting result does not block the next input transfer
// reset (aresetn low, synchronous): table empty, totals and access clock zero,
// active_ways = min(16, FRAMES); depends on lfu_pr_pkg
module lfu_page_replacement #(
    parameter int FRAMES    = 16,
    parameter int PAGE_BITS = 16
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [lfu_pr_pkg::PAGE_IN_W-1:0]     s_tdata,   // page
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // frame, evicted_page, hit_total, miss_total, zero pad
    output logic [lfu_pr_pkg::M_TDATA_W-1:0]     m_tdata,
    output logic [lfu_pr_pkg::M_TUSER_W-1:0]     m_tuser,   // hit, evicted_valid
    input  logic                                 cfg_we,
    input  logic [lfu_pr_pkg::WAYS_W-1:0]        cfg_wdata  // active_ways
);

    localparam int IDX_W  = (FRAMES > 1) ? $clog2(FRAMES) : 1;
    localparam int FILL_W = $clog2(FRAMES + 1);
    localparam int CMP_W  = (FILL_W > lfu_pr_pkg::WAYS_W) ? FILL_W : lfu_pr_pkg::WAYS_W;
    localparam logic [lfu_pr_pkg::WAYS_W-1:0] WAYS_RST =
        lfu_pr_pkg::WAYS_W'((FRAMES < 16) ? FRAMES : 16);

    lfu_pr_pkg::state_t state_reg, state_next;

    logic [PAGE_BITS-1:0]               frame_page  [FRAMES];
    logic [lfu_pr_pkg::COUNT_W-1:0]     frame_count [FRAMES];
    logic [lfu_pr_pkg::STAMP_W-1:0]     frame_stamp [FRAMES];

    logic [FILL_W-1:0]                  filled_reg, filled_next;
    logic [lfu_pr_pkg::STAMP_W-1:0]     clock_reg, clock_next;
    logic [lfu_pr_pkg::TOTAL_W-1:0]     hits_reg, hits_next;
    logic [lfu_pr_pkg::TOTAL_W-1:0]     misses_reg, misses_next;
    logic [lfu_pr_pkg::WAYS_W-1:0]      ways_reg, ways_next;
    logic [IDX_W-1:0]                   rd_idx_reg, rd_idx_next;
    logic                               rvld_reg, rvld_next;
    logic                               found_reg, found_next;
    logic                               m_tvalid_reg, m_tvalid_next;

    logic [PAGE_BITS-1:0]               page_reg;
    logic [lfu_pr_pkg::STAMP_W-1:0]     stamp_reg;
    logic [IDX_W-1:0]                   cmp_idx_reg;
    logic [PAGE_BITS-1:0]               page_q_reg;
    logic [lfu_pr_pkg::COUNT_W-1:0]     count_q_reg;
    logic [lfu_pr_pkg::STAMP_W-1:0]     stamp_q_reg;
    logic [IDX_W-1:0]                   match_idx_reg;
    logic [lfu_pr_pkg::COUNT_W-1:0]     match_count_reg;
    logic [IDX_W-1:0]                   best_idx_reg;
    logic [PAGE_BITS-1:0]               best_page_reg;
    logic [lfu_pr_pkg::COUNT_W-1:0]     best_count_reg;
    logic [lfu_pr_pkg::STAMP_W-1:0]     best_stamp_reg;

    logic                               out_hit_reg;
    logic                               out_ev_valid_reg;
    logic [lfu_pr_pkg::FRAME_OUT_W-1:0] out_frame_reg;
    logic [lfu_pr_pkg::PAGE_IN_W-1:0]   out_ev_page_reg;
    logic [lfu_pr_pkg::TOTAL_W-1:0]     out_hits_reg;
    logic [lfu_pr_pkg::TOTAL_W-1:0]     out_misses_reg;

    logic                               s_accept;
    logic                               decide_go;
    logic                               page_match;
    logic                               victim_better;
    logic                               table_full;
    logic [CMP_W-1:0]                   eff_ways;
    logic [CMP_W-1:0]                   cfg_eff_ways;
    logic [IDX_W-1:0]                   wr_idx;
    logic [lfu_pr_pkg::COUNT_W-1:0]     wr_count;
    logic                               wr_evict;

    function automatic logic [CMP_W-1:0] clamp_ways(input logic [lfu_pr_pkg::WAYS_W-1:0] w);
        logic [CMP_W-1:0] ext;
        ext = CMP_W'(w);
        if (ext == '0) begin
            return CMP_W'(1);
        end else if (ext > CMP_W'(FRAMES)) begin
            return CMP_W'(FRAMES);
        end
        return ext;
    endfunction

    assign eff_ways     = clamp_ways(ways_reg);
    assign cfg_eff_ways = clamp_ways(cfg_wdata);
    assign table_full   = !(CMP_W'(filled_reg) < eff_ways);

    assign s_tready  = (state_reg == lfu_pr_pkg::ST_IDLE);
    assign s_accept  = s_tvalid && s_tready;
    assign decide_go = (state_reg == lfu_pr_pkg::ST_DECIDE) && (!m_tvalid_reg || m_tready);

    // shared compare unit
    assign page_match    = (page_q_reg == page_reg);
    assign victim_better = (cmp_idx_reg == '0) ||
                           (count_q_reg < best_count_reg) ||
                           ((count_q_reg == best_count_reg) && (stamp_q_reg < best_stamp_reg));

    always_comb begin
        wr_evict = 1'b0;
        if (found_reg) begin
            wr_idx   = match_idx_reg;
            wr_count = (match_count_reg == lfu_pr_pkg::COUNT_MAX) ?
                       lfu_pr_pkg::COUNT_MAX : match_count_reg + lfu_pr_pkg::COUNT_NEW;
        end else if (!table_full) begin
            wr_idx   = IDX_W'(filled_reg);
            wr_count = lfu_pr_pkg::COUNT_NEW;
        end else begin
            wr_idx   = best_idx_reg;
            wr_count = lfu_pr_pkg::COUNT_NEW;
            wr_evict = 1'b1;
        end
    end

    always_comb begin
        state_next    = state_reg;
        filled_next   = filled_reg;
        clock_next    = clock_reg;
        hits_next     = hits_reg;
        misses_next   = misses_reg;
        ways_next     = ways_reg;
        rd_idx_next   = rd_idx_reg;
        rvld_next     = 1'b0;
        found_next    = found_reg || (rvld_reg && page_match);
        m_tvalid_next = m_tvalid_reg && !m_tready;

        unique case (state_reg)
            lfu_pr_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    clock_next  = clock_reg + lfu_pr_pkg::STAMP_W'(1);
                    rd_idx_next = '0;
                    found_next  = 1'b0;
                    state_next  = (filled_reg == '0) ? lfu_pr_pkg::ST_DECIDE : lfu_pr_pkg::ST_SCAN;
                end
            end
            lfu_pr_pkg::ST_SCAN: begin
                rvld_next = 1'b1;
                if (FILL_W'(rd_idx_reg) == filled_reg - FILL_W'(1)) begin
                    state_next = lfu_pr_pkg::ST_DRAIN;
                end else begin
                    rd_idx_next = rd_idx_reg + IDX_W'(1);
                end
            end
            lfu_pr_pkg::ST_DRAIN: begin
                state_next = lfu_pr_pkg::ST_DECIDE;
            end
            lfu_pr_pkg::ST_DECIDE: begin
                if (decide_go) begin
                    m_tvalid_next = 1'b1;
                    state_next    = lfu_pr_pkg::ST_IDLE;
                    if (found_reg) begin
                        hits_next = hits_reg + lfu_pr_pkg::TOTAL_W'(1);
                    end else begin
                        misses_next = misses_reg + lfu_pr_pkg::TOTAL_W'(1);
                        if (!table_full) begin
                            filled_next = filled_reg + FILL_W'(1);
                        end
                    end
                end
            end
            default: begin
                state_next = lfu_pr_pkg::ST_IDLE;
            end
        endcase

        if (cfg_we) begin
            ways_next = cfg_wdata;
            if (CMP_W'(filled_reg) > cfg_eff_ways) begin
                filled_next = FILL_W'(cfg_eff_ways);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= lfu_pr_pkg::ST_IDLE;
            filled_reg   <= '0;
            clock_reg    <= '0;
            hits_reg     <= '0;
            misses_reg   <= '0;
            ways_reg     <= WAYS_RST;
            rd_idx_reg   <= '0;
            rvld_reg     <= 1'b0;
            found_reg    <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            filled_reg   <= filled_next;
            clock_reg    <= clock_next;
            hits_reg     <= hits_next;
            misses_reg   <= misses_next;
            ways_reg     <= ways_next;
            rd_idx_reg   <= rd_idx_next;
            rvld_reg     <= rvld_next;
            found_reg    <= found_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // frame table
    always_ff @(posedge aclk) begin
        if (decide_go) begin
            frame_page[wr_idx]  <= page_reg;
            frame_count[wr_idx] <= wr_count;
            frame_stamp[wr_idx] <= stamp_reg;
        end
        if (state_reg == lfu_pr_pkg::ST_SCAN) begin
            page_q_reg  <= frame_page[rd_idx_reg];
            count_q_reg <= frame_count[rd_idx_reg];
            stamp_q_reg <= frame_stamp[rd_idx_reg];
            cmp_idx_reg <= rd_idx_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            page_reg  <= PAGE_BITS'(s_tdata);
            stamp_reg <= clock_reg;
        end
        if (rvld_reg) begin
            if (!found_reg && page_match) begin
                match_idx_reg   <= cmp_idx_reg;
                match_count_reg <= count_q_reg;
            end
            if (victim_better) begin
                best_idx_reg   <= cmp_idx_reg;
                best_page_reg  <= page_q_reg;
                best_count_reg <= count_q_reg;
                best_stamp_reg <= stamp_q_reg;
            end
        end
        if (decide_go) begin
            out_hit_reg      <= found_reg;
            out_ev_valid_reg <= wr_evict;
            out_frame_reg    <= lfu_pr_pkg::FRAME_OUT_W'(wr_idx);
            out_ev_page_reg  <= wr_evict ? lfu_pr_pkg::PAGE_IN_W'(best_page_reg) : '0;
            out_hits_reg     <= hits_next;
            out_misses_reg   <= misses_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = {out_ev_valid_reg, out_hit_reg};
    assign m_tdata  = {{lfu_pr_pkg::M_TDATA_PAD{1'b0}}, out_misses_reg, out_hits_reg,
                       out_ev_page_reg, out_frame_reg};

endmodule

>>> rtl/lfu_pr_checker.sv
// port-level checks for lfu_page_replacement, bound into every lfu_page_replacement instance
// depends on lfu_pr_pkg and assert_macros.svh
`include "assert_macros.svh"

module lfu_pr_checker (
    input logic                             aclk,
    input logic                             aresetn,
    input logic                             s_tvalid,
    input logic                             s_tready,
    input logic                             m_tvalid,
    input logic                             m_tready,
    input logic [lfu_pr_pkg::M_TDATA_W-1:0] m_tdata,
    input logic [lfu_pr_pkg::M_TUSER_W-1:0] m_tuser
);

    `CHK_ASSERT_ACLK(a_out_hold, (m_tvalid && !m_tready) |=> m_tvalid, "result dropped while stalled")
    `CHK_ASSERT_ACLK(a_out_stable, (m_tvalid && !m_tready) |=> ($stable(m_tdata) && $stable(m_tuser)), "stalled result changed")
    `CHK_ASSERT_ACLK(a_evict_not_hit, (m_tvalid && m_tuser[1]) |-> !m_tuser[0], "eviction reported on a hit")
    `CHK_ASSERT_ACLK(a_no_evict_zero, (m_tvalid && !m_tuser[1]) |-> (m_tdata[19:4] == 16'd0), "evicted page nonzero without eviction")
    `CHK_ASSERT_ACLK(a_busy_after_in, (s_tvalid && s_tready) |=> !s_tready, "input taken while lookup in progress")

endmodule

bind lfu_page_replacement lfu_pr_checker u_lfu_pr_checker (.*);
